// ----- sv/guarded_page_frame_allocator_macros.svh -----
// ---------------------------------------------------------------------------
// guarded_page_frame_allocator_macros
// Assertion macros shared by the allocator's checker.
// ---------------------------------------------------------------------------
`ifndef GUARDED_PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define GUARDED_PAGE_FRAME_ALLOCATOR_MACROS_SVH

// Clocked property that is switched off while reset is held.
`define GPFA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked property that is also checked around reset.
`define GPFA_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- sv/gpfa_pkg.sv -----
// ---------------------------------------------------------------------------
// gpfa_pkg
// Types and constants for the guarded page frame allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gpfa_pkg;

    // Commands carried by an input item.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NO_FRAME  = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_DBL_FREE  = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_ISOLATION = 1'b0;
    localparam logic CFG_LOWEST    = 1'b1;

    // A requester or owner with this pid never blocks.
    localparam logic [15:0] SHARED_PID = 16'hFFFE;

    // Per-frame record kept in the frame memory.
    typedef struct packed {
        logic        is_free;
        logic        own_v;
        logic [15:0] pid;
    } frame_info_t;

endpackage

`default_nettype wire

// ----- sv/guarded_page_frame_allocator.sv -----
// Steps: an out-of-range free or an allocate on an empty stack goes straight to the
//   result; a free checks the frame record; a plain allocate pops the top and reads
//   its record; an isolated allocate scans candidates from the top down and then
//   moves the entries above the chosen one down. One item is handled at a time; the
//   next is taken once the last result is offered. The candidate scan and the stack
//   compaction set the rate. Reset: synchronous; the frame memory is then swept clear,
//   during which no item is accepted (configuration is).
// ---------------------------------------------------------------------------
// guarded_page_frame_allocator
// LIFO page frame allocator with owner marks and neighbour isolation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module guarded_page_frame_allocator
    import gpfa_pkg::*;
#(
    parameter int NUM_FRAMES = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // frame_number[9:0], pid[15:0]
    input  wire logic        s_tuser,   // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // status[1:0], granted_frame[9:0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [9:0]  cfg_data
);

    localparam int FW = $clog2(NUM_FRAMES);
    localparam int CW = $clog2(NUM_FRAMES + 1);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_FCHK = 4'd2;
    localparam logic [3:0] S_POP  = 4'd3;
    localparam logic [3:0] S_POPW = 4'd4;
    localparam logic [3:0] S_NB   = 4'd5;
    localparam logic [3:0] S_CK   = 4'd6;
    localparam logic [3:0] S_MV   = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    function automatic logic [FW-1:0] to_idx(input logic [16:0] v);
        to_idx = v[FW-1:0];
    endfunction

    // Memories
    logic [9:0]  stack_mem [NUM_FRAMES];
    frame_info_t info_mem  [NUM_FRAMES];

    logic              st_we;
    logic [FW-1:0]     st_waddr, st_raddr;
    logic [9:0]        st_wdata, st_rdata_reg;
    logic              fm_we;
    logic [FW-1:0]     fm_waddr, fa_addr, fb_addr;
    frame_info_t       fm_wdata, fa_reg, fb_reg;

    // Control and item registers
    logic [3:0]    state_reg, state_next;
    logic [FW-1:0] clr_reg, clr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [FW-1:0] k_reg, k_next;
    logic [9:0]    f_reg, f_next;
    logic          iso_reg;
    logic [9:0]    lowest_reg;
    logic [9:0]    fn_reg, fn_next;
    logic [15:0]   pid_reg, pid_next;
    logic [1:0]    rstat_reg, rstat_next;
    logic [9:0]    rframe_reg, rframe_next;
    logic          ovalid_reg, ovalid_next;
    logic [1:0]    ostat_reg, ostat_next;
    logic [9:0]    oframe_reg, oframe_next;

    logic          in_cmd;
    logic [9:0]    in_fn;
    logic [15:0]   in_pid;
    logic [CW-1:0] cnt_m1;
    logic          lo_blk, hi_blk, cand_ok;
    logic [9:0]    st_f;

    assign in_cmd   = s_tuser;
    assign in_fn    = s_tdata[9:0];
    assign in_pid   = s_tdata[25:10];
    assign cnt_m1   = count_reg - CW'(1);
    assign st_f     = st_rdata_reg;
    assign s_tready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {4'd0, oframe_reg, ostat_reg};

    // Stack memory: one write and one registered read a cycle.
    always_ff @(posedge aclk) begin
        if (st_we) begin
            stack_mem[st_waddr] <= st_wdata;
        end
        st_rdata_reg <= stack_mem[st_raddr];
    end

    // Frame memory: one write and two registered reads a cycle.
    always_ff @(posedge aclk) begin
        if (fm_we) begin
            info_mem[fm_waddr] <= fm_wdata;
        end
        fa_reg <= info_mem[fa_addr];
        fb_reg <= info_mem[fb_addr];
    end

    // Neighbour checks on the frame read out of the stack.
    assign lo_blk  = (f_reg != 10'd0) && fa_reg.own_v && (fa_reg.pid != SHARED_PID)
                     && (fa_reg.pid != pid_reg);
    assign hi_blk  = ((17'(f_reg) + 17'd1) < 17'(NUM_FRAMES)) && fb_reg.own_v
                     && (fb_reg.pid != SHARED_PID) && (fb_reg.pid != pid_reg);
    assign cand_ok = (pid_reg == SHARED_PID) || !(lo_blk || hi_blk);

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        f_next      = f_reg;
        fn_next     = fn_reg;
        pid_next    = pid_reg;
        rstat_next  = rstat_reg;
        rframe_next = rframe_reg;
        st_we       = 1'b0;
        st_waddr    = k_reg;
        st_wdata    = st_f;
        st_raddr    = cnt_m1[FW-1:0];
        fm_we       = 1'b0;
        fm_waddr    = to_idx(17'(f_reg));
        fm_wdata    = '0;
        fa_addr     = to_idx(17'(in_fn));
        fb_addr     = to_idx(17'(f_reg) + 17'd1);

        unique case (state_reg)
            S_CLR: begin
                fm_we    = 1'b1;
                fm_waddr = clr_reg;
                clr_next = clr_reg + FW'(1);
                if (clr_reg == FW'(NUM_FRAMES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    fn_next     = in_fn;
                    pid_next    = in_pid;
                    rframe_next = 10'd0;
                    k_next      = cnt_m1[FW-1:0];
                    if (in_cmd == CMD_FREE) begin
                        if ((in_fn < lowest_reg) ||
                            (17'(in_fn) >= 17'(NUM_FRAMES))) begin
                            rstat_next = ST_RANGE;
                            state_next = S_FIN;
                        end else begin
                            state_next = S_FCHK;
                        end
                    end else if (count_reg == '0) begin
                        rstat_next = ST_NO_FRAME;
                        state_next = S_FIN;
                    end else begin
                        state_next = iso_reg ? S_NB : S_POP;
                    end
                end
            end
            S_FCHK: begin
                fm_waddr = to_idx(17'(fn_reg));
                if (fa_reg.is_free) begin
                    rstat_next = ST_DBL_FREE;
                end else if (count_reg < CW'(NUM_FRAMES)) begin
                    st_we          = 1'b1;
                    st_waddr       = count_reg[FW-1:0];
                    st_wdata       = fn_reg;
                    fm_we          = 1'b1;
                    fm_wdata       = fa_reg;
                    fm_wdata.is_free = 1'b1;
                    if (iso_reg) begin
                        fm_wdata.own_v = 1'b0;
                    end
                    count_next = count_reg + CW'(1);
                    rstat_next = ST_DONE;
                end else begin
                    rstat_next = ST_NO_FRAME;
                end
                state_next = S_FIN;
            end
            S_POP: begin
                f_next     = st_f;
                fa_addr    = to_idx(17'(st_f));
                state_next = S_POPW;
            end
            S_POPW: begin
                fm_we            = 1'b1;
                fm_wdata         = fa_reg;
                fm_wdata.is_free = 1'b0;
                count_next       = cnt_m1;
                rstat_next       = ST_DONE;
                rframe_next      = f_reg;
                state_next       = S_FIN;
            end
            S_NB: begin
                f_next     = st_f;
                fa_addr    = to_idx(17'(st_f) - 17'd1);
                fb_addr    = to_idx(17'(st_f) + 17'd1);
                state_next = S_CK;
            end
            S_CK: begin
                st_raddr = k_reg - FW'(1);
                if (cand_ok) begin
                    fm_we       = 1'b1;
                    fm_wdata    = '{is_free: 1'b0, own_v: 1'b1, pid: pid_reg};
                    rstat_next  = ST_DONE;
                    rframe_next = f_reg;
                    st_raddr    = k_reg + FW'(1);
                    if ((CW'(k_reg) + CW'(1)) < count_reg) begin
                        state_next = S_MV;
                    end else begin
                        count_next = cnt_m1;
                        state_next = S_FIN;
                    end
                end else if (k_reg == '0) begin
                    rstat_next = ST_NO_FRAME;
                    state_next = S_FIN;
                end else begin
                    k_next     = k_reg - FW'(1);
                    state_next = S_NB;
                end
            end
            S_MV: begin
                // Move one entry down a cycle while the next one is read.
                st_we    = 1'b1;
                st_waddr = k_reg;
                st_wdata = st_f;
                k_next   = k_reg + FW'(1);
                st_raddr = k_reg + FW'(2);
                if ((CW'(k_reg) + CW'(2)) >= count_reg) begin
                    count_next = cnt_m1;
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!ovalid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb begin
        ovalid_next = ovalid_reg;
        ostat_next  = ostat_reg;
        oframe_next = oframe_reg;
        if (m_tready) begin
            ovalid_next = 1'b0;
        end
        if ((state_reg == S_FIN) && (!ovalid_reg || m_tready)) begin
            ovalid_next = 1'b1;
            ostat_next  = rstat_reg;
            oframe_next = rframe_reg;
        end
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLR;
            clr_reg    <= '0;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
            iso_reg    <= 1'b0;
            lowest_reg <= 10'd0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
            if (cfg_valid) begin
                if (cfg_index == CFG_ISOLATION) begin
                    iso_reg <= cfg_data[0];
                end else begin
                    lowest_reg <= cfg_data;
                end
            end
        end
        k_reg      <= k_next;
        f_reg      <= f_next;
        fn_reg     <= fn_next;
        pid_reg    <= pid_next;
        rstat_reg  <= rstat_next;
        rframe_reg <= rframe_next;
        ostat_reg  <= ostat_next;
        oframe_reg <= oframe_next;
    end

endmodule

`default_nettype wire

// ----- sv/gpfa_checker.sv -----
// ---------------------------------------------------------------------------
// gpfa_checker
// Port-level checks on the guarded page frame allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "guarded_page_frame_allocator_macros.svh"

module gpfa_checker
    import gpfa_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [31:0] s_tdata,   // frame_number[9:0], pid[15:0]
    input wire logic        s_tuser,   // command
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,   // status[1:0], granted_frame[9:0]
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic        cfg_index,
    input wire logic [9:0]  cfg_data
);

    logic [1:0] m_status;
    logic [9:0] m_frame;

    assign m_status = m_tdata[1:0];
    assign m_frame  = m_tdata[11:2];

    // A waiting result stays offered.
    `GPFA_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid, "result item dropped")

    // Only a successful allocate names a frame.
    `GPFA_ASSERT(a_grant, m_tvalid && (m_status != ST_DONE) |-> (m_frame == '0), "frame on failure")

    // No item is taken just as reset is released and the frame memory clear begins.
    `GPFA_ASSERT_RST(a_clr, aresetn && !$past(aresetn) |-> !s_tready, "item taken during clearing")

endmodule

bind guarded_page_frame_allocator gpfa_checker u_gpfa_checker (.*);

`default_nettype wire

// ----- tb/sv/guarded_page_frame_allocator_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// guarded_page_frame_allocator_tb
// Drives allocate and free items into the page frame allocator and checks
// each result against a behavioural copy of the free stack and owner marks.
// Two short directed tables come first, then random phases with both settings
// of isolation, several lowest-frame limits and varying back-pressure.
// ---------------------------------------------------------------------------
`default_nettype none

module guarded_page_frame_allocator_tb;
    import gpfa_pkg::*;

    localparam int FRAMES      = 1024;
    localparam int STALL_LIMIT = 20000;
    localparam int MAX_REPORTS = 10;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = CMD_ALLOC;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_ISOLATION;
    logic [9:0]  cfg_data = '0;

    guarded_page_frame_allocator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // Shadow copy of the allocator's state.
    logic [9:0]  shadow_stack [FRAMES];
    int          shadow_count;
    logic        shadow_owned [FRAMES];
    logic [15:0] shadow_owner [FRAMES];
    logic        shadow_free  [FRAMES];
    logic        shadow_isolate;
    logic [9:0]  shadow_lowest;

    // Expected results, oldest first: {status, granted_frame}.
    typedef struct packed {
        logic [1:0] status;
        logic [9:0] frame;
    } grant_t;
    grant_t pending_grants[$];

    int mismatches = 0;
    int tx_idle = 0;
    int rx_idle = 0;
    int stall_cycles = 0;
    bit hold_req = 0;
    bit hold_done = 0;
    int hold_left = 0;

    function automatic bit neighbour_blocks(int n, logic [15:0] pid);
        if (n < 0 || n >= FRAMES || !shadow_owned[n]) return 0;
        return shadow_owner[n] != SHARED_PID && shadow_owner[n] != pid;
    endfunction

    // Works out the result of one item and updates the shadow state.
    task automatic apply_request(input logic cmd, input logic [9:0] fn,
                                 input logic [15:0] pid, output grant_t res);
        int k;
        int f;
        res.status = ST_NO_FRAME;
        res.frame  = '0;
        if (cmd == CMD_FREE) begin
            if (fn < shadow_lowest) begin
                res.status = ST_RANGE;
            end else if (shadow_free[fn]) begin
                res.status = ST_DBL_FREE;
            end else if (shadow_count < FRAMES) begin
                shadow_stack[shadow_count] = fn;
                shadow_count++;
                shadow_free[fn] = 1'b1;
                if (shadow_isolate) shadow_owned[fn] = 1'b0;
                res.status = ST_DONE;
            end
        end else if (shadow_count > 0) begin
            if (!shadow_isolate) begin
                shadow_count--;
                res.frame = shadow_stack[shadow_count];
                shadow_free[res.frame] = 1'b0;
                res.status = ST_DONE;
            end else begin
                for (k = shadow_count - 1; k >= 0; k--) begin
                    f = int'(shadow_stack[k]);
                    if (pid == SHARED_PID ||
                        (!neighbour_blocks(f - 1, pid) && !neighbour_blocks(f + 1, pid))) begin
                        for (int m = k; m + 1 < shadow_count; m++)
                            shadow_stack[m] = shadow_stack[m + 1];
                        shadow_count--;
                        shadow_free[f]  = 1'b0;
                        shadow_owned[f] = 1'b1;
                        shadow_owner[f] = pid;
                        res.frame  = f[9:0];
                        res.status = ST_DONE;
                        break;
                    end
                end
            end
        end
    endtask

    // Offers one item, records its expected result once it is accepted.
    task automatic send_request(input logic cmd, input logic [9:0] fn, input logic [15:0] pid,
                                input bit fixed, input grant_t fixed_res);
        grant_t res;
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, pid, fn};
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_request(cmd, fn, pid, res);
        pending_grants.push_back(fixed ? fixed_res : res);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_register(input logic idx, input logic [9:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_ISOLATION) shadow_isolate = value[0];
        else shadow_lowest = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin tx_idle = 24; rx_idle = 58; end
            1: begin tx_idle = 58; rx_idle = 24; end
            default: begin tx_idle = 0; rx_idle = 0; end
        endcase
    endtask

    // Random items: frees cluster near the lowest frame so neighbours interact.
    task automatic random_phase(input int count, input int base);
        logic        cmd;
        logic [9:0]  fn;
        logic [15:0] pid;
        int          r;
        for (int i = 0; i < count; i++) begin
            cmd = ($urandom_range(0, 99) < (shadow_count < 30 ? 55 : 30)) ? CMD_FREE : CMD_ALLOC;
            r = $urandom_range(0, 9);
            if (r == 0) fn = 10'($urandom_range(0, 1023));
            else if (r == 1) fn = 10'(1023 - $urandom_range(0, 3));
            else fn = 10'((base + $urandom_range(0, 40) > 1023) ? 1023
                                                              : base + $urandom_range(0, 40));
            r = $urandom_range(0, 9);
            if (r < 2) pid = SHARED_PID;
            else if (r < 8) pid = 16'($urandom_range(0, 3));
            else pid = 16'($urandom_range(0, 32767));
            send_request(cmd, fn, pid, 1'b0, '0);
        end
    endtask

    // Directed rows; the expected result is typed in where it is obvious.
    typedef struct {
        logic        cmd;
        logic [9:0]  fn;
        logic [15:0] pid;
        bit          fixed;
        logic [1:0]  status;
        logic [9:0]  frame;
    } request_row_t;

    request_row_t plain_rows[7] = '{
        '{CMD_ALLOC, 10'd0,    16'd0,      1, ST_NO_FRAME, 10'd0},
        '{CMD_FREE,  10'd0,    16'd0,      1, ST_DONE,     10'd0},
        '{CMD_FREE,  10'd0,    16'd0,      1, ST_DBL_FREE, 10'd0},
        '{CMD_FREE,  10'd1023, 16'd7,      1, ST_DONE,     10'd0},
        '{CMD_ALLOC, 10'd0,    SHARED_PID, 1, ST_DONE,     10'd1023},
        '{CMD_ALLOC, 10'd1023, 16'd32767,  1, ST_DONE,     10'd0},
        '{CMD_ALLOC, 10'd0,    16'd0,      1, ST_NO_FRAME, 10'd0}
    };

    request_row_t isolated_rows[13] = '{
        '{CMD_FREE,  10'd4,    16'd0,      1, ST_RANGE,    10'd0},
        '{CMD_FREE,  10'd1023, 16'd0,      1, ST_DONE,     10'd0},
        '{CMD_FREE,  10'd6,    16'd0,      1, ST_DONE,     10'd0},
        '{CMD_FREE,  10'd8,    16'd0,      1, ST_DONE,     10'd0},
        '{CMD_FREE,  10'd6,    16'd0,      1, ST_DBL_FREE, 10'd0},
        '{CMD_ALLOC, 10'd0,    16'd1,      0, ST_DONE,     10'd0},
        '{CMD_ALLOC, 10'd0,    16'd2,      0, ST_DONE,     10'd0},
        '{CMD_FREE,  10'd7,    16'd0,      0, ST_DONE,     10'd0},
        '{CMD_ALLOC, 10'd0,    16'd3,      0, ST_DONE,     10'd0},
        '{CMD_ALLOC, 10'd0,    SHARED_PID, 0, ST_DONE,     10'd0},
        '{CMD_FREE,  10'd6,    16'd0,      0, ST_DONE,     10'd0},
        '{CMD_ALLOC, 10'd0,    16'd5,      0, ST_DONE,     10'd0},
        '{CMD_ALLOC, 10'd0,    16'd4,      1, ST_NO_FRAME, 10'd0}
    };

    // Receiver: random back-pressure, plus one long hold-off on request.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1;
            hold_left = 400;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    // Result checker and watchdog.
    always @(posedge aclk) begin
        grant_t got;
        grant_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                got.status = m_tdata[1:0];
                got.frame  = m_tdata[11:2];
                if (pending_grants.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("Unexpected result: status %0d frame %0d",
                                 got.status, got.frame);
                end else begin
                    want = pending_grants.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("Mismatch: expected status %0d frame %0d, got %0d %0d",
                                     want.status, want.frame, got.status, got.frame);
                    end
                end
            end
        end
    end

    initial begin
        shadow_count   = 0;
        shadow_isolate = 1'b0;
        shadow_lowest  = '0;
        for (int i = 0; i < FRAMES; i++) begin
            shadow_owned[i] = 1'b0;
            shadow_free[i]  = 1'b0;
            shadow_owner[i] = '0;
        end
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part with reset settings, then isolation on and a raised floor.
        set_idling(0);
        foreach (plain_rows[i])
            send_request(plain_rows[i].cmd, plain_rows[i].fn, plain_rows[i].pid,
                         plain_rows[i].fixed, {plain_rows[i].status, plain_rows[i].frame});
        drain_results();
        write_register(CFG_ISOLATION, 10'd1);
        write_register(CFG_LOWEST, 10'd5);
        foreach (isolated_rows[i])
            send_request(isolated_rows[i].cmd, isolated_rows[i].fn, isolated_rows[i].pid,
                         isolated_rows[i].fixed,
                         {isolated_rows[i].status, isolated_rows[i].frame});
        drain_results();

        // Random phases; the first one includes the long receiver hold-off.
        write_register(CFG_LOWEST, 10'd0);
        hold_req = 1;
        random_phase(110, 0);
        drain_results();

        write_register(CFG_ISOLATION, 10'd0);
        write_register(CFG_LOWEST, 10'($urandom_range(1, 1000)));
        set_idling(1);
        random_phase(60, int'(shadow_lowest));
        drain_results();

        write_register(CFG_ISOLATION, 10'd1);
        write_register(CFG_LOWEST, 10'd1023);
        random_phase(20, 1000);
        drain_results();

        write_register(CFG_LOWEST, 10'($urandom_range(0, 900)));
        set_idling(2);
        random_phase(80, int'(shadow_lowest));
        drain_results();
        repeat (20) @(posedge aclk);

        if (mismatches == 0 && pending_grants.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
